>>> design/ptri_pkg.sv
// ----------------------------------------------------------------------------
// ptri_pkg
// Shared types and constants of the plane / triangle cut pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptri_pkg;

    localparam int COORD_W  = 32;          // Q16.16 coordinates and Q2.30 normal
    localparam int DIFF_W   = COORD_W + 1; // vertex minus origin
    localparam int TERM_W   = 62;          // one axis product divided by four
    localparam int DIST_W   = 64;          // signed distance, units of 2^-44
    localparam int MAG_W    = DIST_W - 1;  // magnitude of one distance
    localparam int QUO_W    = COORD_W + 1; // quotient bits of the crossing offset
    localparam int NUM_W    = 96;          // distance magnitude times edge span
    localparam int DIV_LAT  = QUO_W + 5;   // latency of one crossing lane
    localparam int DIST_LAT = 3;           // latency of the distance stages
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_SEG  = 2'd2;

    localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sh4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t normal;
        vec_t origin;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tri_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        point_count;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } seg_item_t;

    typedef struct packed {
        vec_t                     a;
        vec_t                     b;
        vec_t                     c;
        logic signed [DIST_W-1:0] da;
        logic signed [DIST_W-1:0] db;
        logic signed [DIST_W-1:0] dc;
    } dist_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       point_count;
        vec_t                     p0;
        vec_t                     r0;
        logic signed [DIST_W-1:0] dp0;
        logic signed [DIST_W-1:0] dr0;
        vec_t                     p1;
        vec_t                     r1;
        logic signed [DIST_W-1:0] dp1;
        logic signed [DIST_W-1:0] dr1;
    } edge_t;

endpackage

`default_nettype wire

>>> design/ptri_stream_if.sv
// ----------------------------------------------------------------------------
// ptri_stream_if
// Valid / ready channel that carries one item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptri_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/ptri_dist.sv
// ----------------------------------------------------------------------------
// ptri_dist
// Three stages that form the signed plane distance of each vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module ptri_dist (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire ptri_pkg::tri_item_t item,
    input  wire ptri_pkg::plane_t    plane,
    output logic                     out_valid,
    output ptri_pkg::dist_t          vdist
);

    logic signed [ptri_pkg::COORD_W-1:0]  vtx      [3][3];
    logic signed [ptri_pkg::COORD_W-1:0]  nrm      [3];
    logic signed [ptri_pkg::COORD_W-1:0]  org      [3];
    logic signed [2*ptri_pkg::DIFF_W-2:0] prod     [3][3];

    logic signed [ptri_pkg::DIFF_W-1:0]   diff_reg [3][3];
    logic signed [ptri_pkg::TERM_W-1:0]   term_reg [3][3];
    logic signed [ptri_pkg::DIST_W-1:0]   dist_reg [3];
    logic signed [ptri_pkg::COORD_W-1:0]  v1_reg   [3][3];
    logic signed [ptri_pkg::COORD_W-1:0]  v2_reg   [3][3];
    logic signed [ptri_pkg::COORD_W-1:0]  v3_reg   [3][3];
    logic [ptri_pkg::DIST_LAT-1:0]        vld_reg;

    always_comb
    begin
        vtx[0][0] = item.a_x; vtx[0][1] = item.a_y; vtx[0][2] = item.a_z;
        vtx[1][0] = item.b_x; vtx[1][1] = item.b_y; vtx[1][2] = item.b_z;
        vtx[2][0] = item.c_x; vtx[2][1] = item.c_y; vtx[2][2] = item.c_z;
        nrm[0] = plane.normal.x; nrm[1] = plane.normal.y; nrm[2] = plane.normal.z;
        org[0] = plane.origin.x; org[1] = plane.origin.y; org[2] = plane.origin.z;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod[i][j] = diff_reg[i][j] * nrm[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ptri_pkg::DIST_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    diff_reg[i][j] <= {vtx[i][j][ptri_pkg::COORD_W-1], vtx[i][j]}
                                    - {org[j][ptri_pkg::COORD_W-1], org[j]};
                    // The product always fits 64 bits; dropping two bits floors it.
                    term_reg[i][j] <= prod[i][j][ptri_pkg::DIST_W-1:2];
                    v1_reg[i][j]   <= vtx[i][j];
                    v2_reg[i][j]   <= v1_reg[i][j];
                    v3_reg[i][j]   <= v2_reg[i][j];
                end
                dist_reg[i] <= {{2{term_reg[i][0][ptri_pkg::TERM_W-1]}}, term_reg[i][0]}
                             + {{2{term_reg[i][1][ptri_pkg::TERM_W-1]}}, term_reg[i][1]}
                             + {{2{term_reg[i][2][ptri_pkg::TERM_W-1]}}, term_reg[i][2]};
            end
        end
    end

    assign out_valid = vld_reg[ptri_pkg::DIST_LAT-1];

    always_comb
    begin
        vdist.a  = '{x: v3_reg[0][0], y: v3_reg[0][1], z: v3_reg[0][2]};
        vdist.b  = '{x: v3_reg[1][0], y: v3_reg[1][1], z: v3_reg[1][2]};
        vdist.c  = '{x: v3_reg[2][0], y: v3_reg[2][1], z: v3_reg[2][2]};
        vdist.da = dist_reg[0];
        vdist.db = dist_reg[1];
        vdist.dc = dist_reg[2];
    end

endmodule

`default_nettype wire

>>> design/ptri_edge.sv
// ----------------------------------------------------------------------------
// ptri_edge
// Classifies the vertices and picks the pair of edges that change side.
// ----------------------------------------------------------------------------
`default_nettype none

module ptri_edge (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire ptri_pkg::dist_t vdist,
    output logic                 out_valid,
    output ptri_pkg::edge_t      cut
);

    ptri_pkg::edge_t cut_next;
    ptri_pkg::edge_t cut_reg;
    logic            vld_reg;
    logic            sa;
    logic            sb;
    logic            sc;

    always_comb
    begin
        sa = vdist.da[ptri_pkg::DIST_W-1];
        sb = vdist.db[ptri_pkg::DIST_W-1];
        sc = vdist.dc[ptri_pkg::DIST_W-1];
        cut_next             = '0;
        cut_next.point_count = ptri_pkg::COUNT_NONE;
        // First endpoint on AB when A and B differ, else on AC; the second
        // endpoint prefers AC after AB and otherwise takes BC.
        if (sa != sb)
        begin
            cut_next.point_count = ptri_pkg::COUNT_SEG;
            cut_next.p0  = vdist.a;  cut_next.r0  = vdist.b;
            cut_next.dp0 = vdist.da; cut_next.dr0 = vdist.db;
            if (sa != sc)
            begin
                cut_next.p1  = vdist.a;  cut_next.r1  = vdist.c;
                cut_next.dp1 = vdist.da; cut_next.dr1 = vdist.dc;
            end
            else
            begin
                cut_next.p1  = vdist.b;  cut_next.r1  = vdist.c;
                cut_next.dp1 = vdist.db; cut_next.dr1 = vdist.dc;
            end
        end
        else if (sa != sc)
        begin
            cut_next.point_count = ptri_pkg::COUNT_SEG;
            cut_next.p0  = vdist.a;  cut_next.r0  = vdist.c;
            cut_next.dp0 = vdist.da; cut_next.dr0 = vdist.dc;
            cut_next.p1  = vdist.b;  cut_next.r1  = vdist.c;
            cut_next.dp1 = vdist.db; cut_next.dr1 = vdist.dc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cut_reg <= cut_next;
        end
    end

    assign out_valid = vld_reg;
    assign cut       = cut_reg;

endmodule

`default_nettype wire

>>> design/ptri_div.sv
// ----------------------------------------------------------------------------
// ptri_div
// One coordinate of one crossing: P + trunc(|dP| * (R - P) / (|dP| + |dR|)),
// with a split multiply and a restoring divider of one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptri_div (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [ptri_pkg::COORD_W-1:0] p,
    input  wire logic signed [ptri_pkg::COORD_W-1:0] r,
    input  wire logic signed [ptri_pkg::DIST_W-1:0]  dp,
    input  wire logic signed [ptri_pkg::DIST_W-1:0]  dr,
    output logic signed [ptri_pkg::COORD_W-1:0]      u
);

    localparam int CW = ptri_pkg::COORD_W;
    localparam int DW = ptri_pkg::DIST_W;
    localparam int MW = ptri_pkg::MAG_W;
    localparam int QW = ptri_pkg::QUO_W;
    localparam int NW = ptri_pkg::NUM_W;
    localparam int LW = CW + QW;            // low partial product
    localparam int HW = MW - CW + QW;       // high partial product

    logic [DW-1:0]          abs_dp;
    logic [DW-1:0]          abs_dr;

    // Stage A: magnitudes and edge span.
    logic [MW-1:0]          mp_a_reg;
    logic [MW-1:0]          mr_a_reg;
    logic signed [QW-1:0]   delta_a_reg;
    logic signed [CW-1:0]   p_a_reg;
    // Stage B: denominator and span magnitude.
    logic [MW-1:0]          mp_b_reg;
    logic [DW-1:0]          den_b_reg;
    logic [QW-1:0]          dmag_b_reg;
    logic                   neg_b_reg;
    logic signed [CW-1:0]   p_b_reg;
    // Stage C: partial products.
    logic [LW-1:0]          lo_c_reg;
    logic [HW-1:0]          hi_c_reg;
    logic [DW-1:0]          den_c_reg;
    logic                   neg_c_reg;
    logic signed [CW-1:0]   p_c_reg;

    logic [NW-1:0]          num_d;

    // Divider stages; entry 0 is loaded from the numerator sum.
    logic [DW-1:0]          rem_reg [QW+1];
    logic [QW-1:0]          bits_reg [QW+1];
    logic [QW-1:0]          quo_reg [QW+1];
    logic [DW-1:0]          den_reg [QW+1];
    logic                   neg_reg [QW+1];
    logic signed [CW-1:0]   p_reg   [QW+1];

    logic [CW+1:0]          sum_next;
    logic signed [CW-1:0]   u_reg;

    always_comb
    begin
        abs_dp   = dp[DW-1] ? -dp : dp;
        abs_dr   = dr[DW-1] ? -dr : dr;
        num_d    = {{(NW-LW){1'b0}}, lo_c_reg} + {hi_c_reg, {CW{1'b0}}};
        sum_next = neg_reg[QW]
                 ? {{2{p_reg[QW][CW-1]}}, p_reg[QW]} - {1'b0, quo_reg[QW]}
                 : {{2{p_reg[QW][CW-1]}}, p_reg[QW]} + {1'b0, quo_reg[QW]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_a_reg    <= abs_dp[MW-1:0];
            mr_a_reg    <= abs_dr[MW-1:0];
            delta_a_reg <= {r[CW-1], r} - {p[CW-1], p};
            p_a_reg     <= p;

            mp_b_reg    <= mp_a_reg;
            den_b_reg   <= {1'b0, mp_a_reg} + {1'b0, mr_a_reg};
            dmag_b_reg  <= delta_a_reg[QW-1] ? -delta_a_reg : delta_a_reg;
            neg_b_reg   <= delta_a_reg[QW-1];
            p_b_reg     <= p_a_reg;

            lo_c_reg    <= {{(LW-CW){1'b0}}, mp_b_reg[CW-1:0]} * {{(LW-QW){1'b0}}, dmag_b_reg};
            hi_c_reg    <= {{(HW-MW+CW){1'b0}}, mp_b_reg[MW-1:CW]}
                         * {{(HW-QW){1'b0}}, dmag_b_reg};
            den_c_reg   <= den_b_reg;
            neg_c_reg   <= neg_b_reg;
            p_c_reg     <= p_b_reg;

            // The quotient never exceeds the span, so the top bits start below den.
            rem_reg[0]  <= {{(DW-(NW-QW)){1'b0}}, num_d[NW-1:QW]};
            bits_reg[0] <= num_d[QW-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den_c_reg;
            neg_reg[0]  <= neg_c_reg;
            p_reg[0]    <= p_c_reg;

            u_reg       <= sum_next[CW-1:0];
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[s], bits_reg[s][QW-1]};
            diff  = trial - {1'b0, den_reg[s]};
            ge    = trial >= {1'b0, den_reg[s]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                bits_reg[s+1] <= {bits_reg[s][QW-2:0], 1'b0};
                quo_reg[s+1]  <= {quo_reg[s][QW-2:0], ge};
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                p_reg[s+1]    <= p_reg[s];
            end
        end
    end

    assign u = u_reg;

endmodule

`default_nettype wire

>>> design/ptri_cross.sv
// ----------------------------------------------------------------------------
// ptri_cross
// Six crossing lanes, one per endpoint coordinate, with the item's valid bit
// and point count carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ptri_cross (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire ptri_pkg::edge_t cut,
    output logic                 out_valid,
    output ptri_pkg::seg_item_t  seg
);

    localparam int LAT = ptri_pkg::DIV_LAT;

    logic [LAT-1:0]                 vld_reg;
    logic [ptri_pkg::COUNT_W-1:0]   cnt_reg [LAT];
    logic signed [ptri_pkg::COORD_W-1:0] u0x, u0y, u0z, u1x, u1y, u1z;
    logic                           hit;

    ptri_div u_div_0x (.clk(clk), .en(en), .p(cut.p0.x), .r(cut.r0.x),
                       .dp(cut.dp0), .dr(cut.dr0), .u(u0x));
    ptri_div u_div_0y (.clk(clk), .en(en), .p(cut.p0.y), .r(cut.r0.y),
                       .dp(cut.dp0), .dr(cut.dr0), .u(u0y));
    ptri_div u_div_0z (.clk(clk), .en(en), .p(cut.p0.z), .r(cut.r0.z),
                       .dp(cut.dp0), .dr(cut.dr0), .u(u0z));
    ptri_div u_div_1x (.clk(clk), .en(en), .p(cut.p1.x), .r(cut.r1.x),
                       .dp(cut.dp1), .dr(cut.dr1), .u(u1x));
    ptri_div u_div_1y (.clk(clk), .en(en), .p(cut.p1.y), .r(cut.r1.y),
                       .dp(cut.dp1), .dr(cut.dr1), .u(u1y));
    ptri_div u_div_1z (.clk(clk), .en(en), .p(cut.p1.z), .r(cut.r1.z),
                       .dp(cut.dp1), .dr(cut.dr1), .u(u1z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg[0] <= cut.point_count;
            for (int i = 1; i < LAT; i++)
            begin
                cnt_reg[i] <= cnt_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];

    // Without a crossing the lanes run on meaningless data; the fields read zero.
    always_comb
    begin
        hit              = cnt_reg[LAT-1] != ptri_pkg::COUNT_NONE;
        seg.point_count  = cnt_reg[LAT-1];
        seg.first_x      = hit ? u0x : '0;
        seg.first_y      = hit ? u0y : '0;
        seg.first_z      = hit ? u0z : '0;
        seg.second_x     = hit ? u1x : '0;
        seg.second_y     = hit ? u1y : '0;
        seg.second_z     = hit ? u1z : '0;
    end

endmodule

`default_nettype wire

>>> design/plane_triangle_intersect_top.sv
// ----------------------------------------------------------------------------
// plane_triangle_intersect_top
// Cuts a stream of triangles with one configured plane and returns the
// segment where the plane crosses each triangle.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake        Contents
//   triangle   in         valid / ready    vertices A, B, C in Q16.16
//   segment    out        valid / ready    point count and two endpoints
//   cfg        in         write enable     plane normal (Q2.30) and origin
//
// One triangle enters per cycle while triangle ready is high. Each passes three
// stages for the vertex distances, one for edge selection, 38 in each crossing
// lane (four for magnitudes and the split multiply, 33 restoring divider steps
// of one quotient bit each, one for the final add), and the output register.
// Reset clears all valid bits and loads the default plane z = 0.
// A stall on the segment side is absorbed by a skid register behind the output
// register; the pipeline freezes as a whole only once that skid register holds
// an item, so triangle ready is a plain register output.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_triangle_intersect_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    ptri_stream_if.sink                                triangle,
    ptri_stream_if.source                              segment,
    input  wire logic                                  cfg_we,
    input  wire logic [ptri_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ptri_pkg::COORD_W-1:0]          cfg_data
);

    ptri_pkg::plane_t    plane_reg;
    logic                en;

    logic                dist_valid;
    ptri_pkg::dist_t     vdist;
    logic                edge_valid;
    ptri_pkg::edge_t     cut;
    logic                cross_valid;
    ptri_pkg::seg_item_t cross_seg;

    logic                out_valid_reg;
    ptri_pkg::seg_item_t out_data_reg;
    logic                skid_valid_reg;
    ptri_pkg::seg_item_t skid_data_reg;
    logic                push;
    logic                pop;

    // Plane registers. User writes only while the pipeline is empty; no check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '{normal: '{x: '0, y: '0, z: ptri_pkg::NORMAL_Z_RESET},
                           origin: '0};
        end
        else if (cfg_we)
        begin
            unique case (ptri_pkg::cfg_idx_t'(cfg_index))
                ptri_pkg::CFG_NORMAL_X: plane_reg.normal.x <= cfg_data;
                ptri_pkg::CFG_NORMAL_Y: plane_reg.normal.y <= cfg_data;
                ptri_pkg::CFG_NORMAL_Z: plane_reg.normal.z <= cfg_data;
                ptri_pkg::CFG_ORIGIN_X: plane_reg.origin.x <= cfg_data;
                ptri_pkg::CFG_ORIGIN_Y: plane_reg.origin.y <= cfg_data;
                ptri_pkg::CFG_ORIGIN_Z: plane_reg.origin.z <= cfg_data;
                default:                ;
            endcase
        end
    end

    // The pipeline advances whenever the skid register is free; then the
    // output register and the skid register together always have room.
    assign en             = !skid_valid_reg;
    assign triangle.ready = en;

    ptri_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (triangle.valid),
        .item      (triangle.data),
        .plane     (plane_reg),
        .out_valid (dist_valid),
        .vdist     (vdist)
    );

    ptri_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dist_valid),
        .vdist     (vdist),
        .out_valid (edge_valid),
        .cut       (cut)
    );

    ptri_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (edge_valid),
        .cut       (cut),
        .out_valid (cross_valid),
        .seg       (cross_seg)
    );

    assign push = en && cross_valid;
    assign pop  = out_valid_reg && segment.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= cross_seg;
            end
            else
            begin
                out_data_reg <= cross_seg;
            end
        end
    end

    assign segment.valid = out_valid_reg;
    assign segment.data  = out_data_reg;

endmodule

`default_nettype wire
